[rtl/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, constants and the segment decode for the seven-segment latch.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int unsigned DIGITS     = 4;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned PORT_IDX_W = 2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [PORT_IDX_W-1:0] WATCHED_PORT_RST = '0;

  typedef struct packed {
    logic                  req_type;
    logic [PORT_IDX_W-1:0] port_index;
    logic [7:0]            port_value;
  } in_t;

  typedef struct packed {
    logic [SEG_W-1:0] digit3_segments;
    logic [SEG_W-1:0] digit2_segments;
    logic [SEG_W-1:0] digit1_segments;
    logic [SEG_W-1:0] digit0_segments;
  } out_t;

  // Decoded request handed from the input stage to the digit state.
  typedef struct packed {
    logic        tick;
    logic        write;
    logic [7:0]  value;
  } cmd_t;

  // Lit pattern for a hex digit: complement of the inverted segment table.
  function automatic logic [SEG_W-1:0] seg_lit(input logic [3:0] hex);
    logic [SEG_W-1:0] inv;
    unique case (hex)
      4'h0: inv = 8'h40;
      4'h1: inv = 8'h79;
      4'h2: inv = 8'h24;
      4'h3: inv = 8'h30;
      4'h4: inv = 8'h19;
      4'h5: inv = 8'h12;
      4'h6: inv = 8'h02;
      4'h7: inv = 8'h78;
      4'h8: inv = 8'h00;
      4'h9: inv = 8'h10;
      4'hA: inv = 8'h08;
      4'hB: inv = 8'h03;
      4'hC: inv = 8'h46;
      4'hD: inv = 8'h21;
      4'hE: inv = 8'h06;
      4'hF: inv = 8'h0E;
      default: inv = 8'h00;
    endcase
    return ~inv;
  endfunction

endpackage

[rtl/mss_in_reg.sv]
// ----------------------------------------------------------------------------
// mss_in_reg
// Input register: holds one accepted beat and decodes it against the
// watched port.
// ----------------------------------------------------------------------------
module mss_in_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mss_pkg::in_t                   in_data,
  input  logic [mss_pkg::PORT_IDX_W-1:0] watched_port,
  input  logic                           adv,
  output logic                           cmd_valid,
  output mss_pkg::cmd_t                  cmd
);
  import mss_pkg::*;

  logic valid_r;
  logic valid_nxt;
  in_t  data_r;

  assign in_ready  = !valid_r || adv;
  assign valid_nxt = in_valid ? 1'b1 : (adv ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign cmd_valid = valid_r;

  always_comb begin
    cmd.tick  = (data_r.req_type == REQ_TICK);
    cmd.write = (data_r.req_type == REQ_WRITE) && (data_r.port_index == watched_port);
    cmd.value = data_r.port_value;
  end

endmodule

[rtl/mss_digits.sv]
// ----------------------------------------------------------------------------
// mss_digits
// Digit state: latched patterns, refreshed marks and the last select nibble,
// updated once per advancing beat.
// ----------------------------------------------------------------------------
module mss_digits (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          adv,
  input  mss_pkg::cmd_t                                 cmd,
  output logic [mss_pkg::DIGITS-1:0][mss_pkg::SEG_W-1:0] pat_nxt
);
  import mss_pkg::*;

  logic [DIGITS-1:0][SEG_W-1:0] pat_r;
  logic [DIGITS-1:0]            mark_r;
  logic [DIGITS-1:0]            mark_nxt;
  logic [DIGITS-1:0]            sel_r;
  logic [DIGITS-1:0]            sel_nxt;
  logic [SEG_W-1:0]             lit;
  logic [DIGITS-1:0]            sel_in;

  assign lit    = seg_lit(cmd.value[3:0]);
  assign sel_in = cmd.value[7:4];

  always_comb begin
    pat_nxt  = pat_r;
    mark_nxt = mark_r;
    sel_nxt  = sel_r;
    for (int i = 0; i < DIGITS; i++) begin
      if (cmd.tick) begin
        // Drop a digit that was left unselected and not refreshed since the last tick.
        if (sel_r[i] && (pat_r[i] != '0) && !mark_r[i]) begin
          pat_nxt[i] = '0;
        end else begin
          mark_nxt[i] = 1'b0;
        end
      end else if (cmd.write && !sel_in[i]) begin
        pat_nxt[i]  = lit;
        mark_nxt[i] = 1'b1;
      end
    end
    if (!cmd.tick && cmd.write) begin
      sel_nxt = sel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      mark_r <= '0;
      sel_r  <= '1;
    end else if (adv) begin
      pat_r  <= pat_nxt;
      mark_r <= mark_nxt;
      sel_r  <= sel_nxt;
    end
  end

endmodule

[rtl/multiplexed_seven_segment_latch.sv]
// Path: the input register loads at the accept edge; the result register loads
//   together with the digit state when the beat advances.
// Throughput: one item per cycle while out_ready does not stall the result.
// Stalls on out_ready hold the result and back-pressure through the input stage.
// Reset (rst_n, synchronous): digits dark, marks clear, no digit selected,
//   watched port 0.
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_latch
// Four-digit multiplexed seven-segment latch with persistence ticks.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_latch (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mss_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mss_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mss_pkg::PORT_IDX_W-1:0] cfg_watched_port
);
  import mss_pkg::*;

  logic [PORT_IDX_W-1:0]        watched_port_r;
  logic                         cmd_valid;
  cmd_t                         cmd;
  logic                         adv;
  logic [DIGITS-1:0][SEG_W-1:0] pat_nxt;
  logic                         out_valid_r;
  out_t                         out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watched_port_r <= WATCHED_PORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      watched_port_r <= cfg_watched_port;
    end
  end

  // Advance when the result register is free or being emptied.
  assign adv = cmd_valid && (!out_valid_r || out_ready);

  mss_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .watched_port (watched_port_r),
    .adv          (adv),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  mss_digits u_digits (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cmd     (cmd),
    .pat_nxt (pat_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.digit0_segments <= pat_nxt[0];
      out_data_r.digit1_segments <= pat_nxt[1];
      out_data_r.digit2_segments <= pat_nxt[2];
      out_data_r.digit3_segments <= pat_nxt[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/mss_checker.sv]
// ----------------------------------------------------------------------------
// mss_port_checker
// Port-level checks for the seven-segment latch, bound to the top level.
// ----------------------------------------------------------------------------
module mss_port_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          out_valid,
  input  logic          out_ready,
  input  mss_pkg::out_t out_data
);
  import mss_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Every digit is either dark or a lit pattern with bit 7 set.
  a_lit_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.digit0_segments == '0 || out_data.digit0_segments[SEG_W-1]) &&
      (out_data.digit1_segments == '0 || out_data.digit1_segments[SEG_W-1]) &&
      (out_data.digit2_segments == '0 || out_data.digit2_segments[SEG_W-1]) &&
      (out_data.digit3_segments == '0 || out_data.digit3_segments[SEG_W-1]))
    else $error("digit pattern neither dark nor lit");

  // No result beat right after reset.
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multiplexed_seven_segment_latch mss_port_checker u_mss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[dv/mss_checker.sv]
// ----------------------------------------------------------------------------
// mss_checker
// Watches the input, result and register channels of the seven-segment latch,
// keeps its own copy of the digit state to predict each result beat, and
// compares every result beat digit by digit against the oldest prediction.
// ----------------------------------------------------------------------------
module mss_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  mss_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  mss_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mss_pkg::PORT_IDX_W-1:0] cfg_watched_port,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mss_pkg::*;

  localparam logic [SEG_W-1:0] SEG_DARK  = '0;
  localparam int unsigned      SHOW_MAX  = 10;

  logic [SEG_W-1:0]      pattern [DIGITS];
  logic                  fresh   [DIGITS];
  logic [DIGITS-1:0]     held_sel;
  logic [PORT_IDX_W-1:0] watched;
  out_t                  shown_q [$];

  // Segments that light for a hex digit; bit 7 (the point) always reads 1.
  function automatic logic [SEG_W-1:0] lit_pattern(input logic [3:0] hex);
    logic [SEG_W-1:0] seg;
    case (hex)
      4'h0: seg = 8'hBF;
      4'h1: seg = 8'h86;
      4'h2: seg = 8'hDB;
      4'h3: seg = 8'hCF;
      4'h4: seg = 8'hE6;
      4'h5: seg = 8'hED;
      4'h6: seg = 8'hFD;
      4'h7: seg = 8'h87;
      4'h8: seg = 8'hFF;
      4'h9: seg = 8'hEF;
      4'hA: seg = 8'hF7;
      4'hB: seg = 8'hFC;
      4'hC: seg = 8'hB9;
      4'hD: seg = 8'hDE;
      4'hE: seg = 8'hF9;
      default: seg = 8'hF1;
    endcase
    return seg;
  endfunction

  // Apply one input beat to the digit state and return the panel it leaves.
  function automatic out_t advance_display(input in_t beat);
    out_t shown;
    if (beat.req_type == REQ_TICK) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (held_sel[d] && pattern[d] != SEG_DARK && !fresh[d]) begin
          pattern[d] = SEG_DARK;
        end else begin
          fresh[d] = 1'b0;
        end
      end
    end else if (beat.port_index == watched) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (!beat.port_value[4+d]) begin
          pattern[d] = lit_pattern(beat.port_value[3:0]);
          fresh[d]   = 1'b1;
        end
      end
      held_sel = beat.port_value[7:4];
    end
    shown.digit0_segments = pattern[0];
    shown.digit1_segments = pattern[1];
    shown.digit2_segments = pattern[2];
    shown.digit3_segments = pattern[3];
    return shown;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    logic bad;
    if (!rst_n) begin
      for (int d = 0; d < DIGITS; d++) begin
        pattern[d] = SEG_DARK;
        fresh[d]   = 1'b0;
      end
      held_sel    = '1;
      watched     = WATCHED_PORT_RST;
      shown_q.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      // Pop before push: a result never leaves in the cycle its input enters.
      if (out_valid && out_ready) begin
        if (shown_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX) begin
            $display("%0t: result beat %h with nothing predicted", $realtime, out_data);
          end
        end else begin
          want = shown_q.pop_front();
          bad  = 1'b0;
          for (int d = 0; d < DIGITS; d++) begin
            if (out_data[d*SEG_W +: SEG_W] !== want[d*SEG_W +: SEG_W]) begin
              bad = 1'b1;
            end
          end
          if (bad) begin
            mismatches++;
            if (mismatches <= SHOW_MAX) begin
              for (int d = 0; d < DIGITS; d++) begin
                if (out_data[d*SEG_W +: SEG_W] !== want[d*SEG_W +: SEG_W]) begin
                  $display("%0t: digit%0d segments expected %h, got %h", $realtime, d,
                           want[d*SEG_W +: SEG_W], out_data[d*SEG_W +: SEG_W]);
                end
              end
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        shown_q.push_back(advance_display(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        watched = cfg_watched_port;
      end
      outstanding = shown_q.size();
    end
  end

endmodule

[dv/tb_multiplexed_seven_segment_latch.sv]
// ----------------------------------------------------------------------------
// tb_multiplexed_seven_segment_latch
// Drives port writes and persistence ticks into the seven-segment latch under
// each watched-port setting, with random idle bursts on both channels and one
// long result stall; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_multiplexed_seven_segment_latch;
  timeunit 1ns;
  timeprecision 1ps;
  import mss_pkg::*;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [PORT_IDX_W-1:0] cfg_watched_port;

  int unsigned           mismatches;
  int unsigned           outstanding;
  int unsigned           quiet_cycles = 0;
  logic                  bursts_on;
  logic                  hold_request;
  logic [PORT_IDX_W-1:0] watched;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multiplexed_seven_segment_latch DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_watched_port (cfg_watched_port)
  );

  mss_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_watched_port (cfg_watched_port),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin : result_side
    logic held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
        out_ready <= 1'b1;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input in_t beat);
    int unsigned gap;
    gap = (bursts_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic kind, input logic [1:0] port,
                             input logic [7:0] value);
    in_t beat;
    beat.req_type   = kind;
    beat.port_index = port;
    beat.port_value = value;
    send_item(beat);
  endtask

  // Write the watched-port register once every predicted result is out.
  task automatic set_watched(input logic [PORT_IDX_W-1:0] port);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_watched_port <= port;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    watched    = port;
  endtask

  // Mostly multiplexed scans of the watched port: one digit selected at a
  // time, interleaved with ticks; the rest is odd select masks and writes
  // to other ports.
  function automatic in_t random_beat();
    in_t         beat;
    int unsigned roll;
    roll            = $urandom_range(0, 99);
    beat.req_type   = REQ_WRITE;
    beat.port_index = watched;
    beat.port_value = 8'($urandom_range(0, 255));
    if (roll < 25) begin
      beat.req_type   = REQ_TICK;
      beat.port_index = PORT_IDX_W'($urandom_range(0, 3));
    end else if (roll < 35) begin
      beat.port_index = PORT_IDX_W'($urandom_range(0, 3));
    end else if (roll < 80) begin
      beat.port_value[7:4] = ~(4'b0001 << $urandom_range(0, 3));
    end
    return beat;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned hold_at);
    in_t         beat;
    int unsigned counted;
    counted = 0;
    while (counted < count) begin
      beat = random_beat();
      if (hold_at != 0 && counted == hold_at) begin
        hold_request = 1'b1;
      end
      send_item(beat);
      counted++;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    cfg_valid        = 1'b0;
    cfg_watched_port = '0;
    bursts_on        = 1'b1;
    hold_request     = 1'b0;
    watched          = WATCHED_PORT_RST;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: tick on a dark panel, scan digits, let unrefreshed ones fade.
    send_fields(REQ_TICK,  2'd0, 8'h00);
    send_fields(REQ_WRITE, 2'd0, 8'hE0);
    send_fields(REQ_WRITE, 2'd0, 8'hD1);
    send_fields(REQ_WRITE, 2'd0, 8'hB2);
    send_fields(REQ_WRITE, 2'd0, 8'h73);
    send_fields(REQ_TICK,  2'd0, 8'h00);
    send_fields(REQ_TICK,  2'd3, 8'hFF);
    // All digits at once, then a write that selects none.
    send_fields(REQ_WRITE, 2'd0, 8'h0F);
    send_fields(REQ_WRITE, 2'd0, 8'hF5);
    send_fields(REQ_TICK,  2'd1, 8'hA5);
    send_fields(REQ_TICK,  2'd2, 8'h5A);
    // Writes to unwatched ports.
    send_fields(REQ_WRITE, 2'd1, 8'h08);
    send_fields(REQ_WRITE, 2'd2, 8'h39);
    send_fields(REQ_WRITE, 2'd3, 8'h00);
    // Remaining hex digits on rotating selects.
    send_fields(REQ_WRITE, 2'd0, 8'hE4);
    send_fields(REQ_WRITE, 2'd0, 8'hD6);
    send_fields(REQ_WRITE, 2'd0, 8'hB7);
    send_fields(REQ_WRITE, 2'd0, 8'h78);
    send_fields(REQ_WRITE, 2'd0, 8'hC9);
    send_fields(REQ_WRITE, 2'd0, 8'h3A);
    send_fields(REQ_WRITE, 2'd0, 8'hAB);
    send_fields(REQ_WRITE, 2'd0, 8'h5C);
    send_fields(REQ_WRITE, 2'd0, 8'h9D);
    send_fields(REQ_WRITE, 2'd0, 8'h6E);

    set_watched(2'd3);
    run_random(300, 120);
    set_watched(2'd1);
    run_random(250, 0);
    set_watched(2'd2);
    run_random(250, 0);
    // Last part at full rate with no idling on either side.
    bursts_on = 1'b0;
    set_watched(2'd0);
    run_random(300, 0);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
